@@ rtl/nsv_pkg.sv @@
// shared types, character codes and helper functions for the sentence checker
`default_nettype none

package nsv_pkg;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_A      = 8'h41;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_UP_A   = 8'h41;
    localparam logic [7:0] CHAR_UP_F   = 8'h46;
    localparam logic [7:0] CHAR_LO_A   = 8'h61;
    localparam logic [7:0] CHAR_LO_F   = 8'h66;

    localparam logic [2:0] TIME_DIGITS   = 3'd6;
    localparam logic [2:0] TIME_TOO_LONG = 3'd7;
    localparam logic [1:0] FIELD_TIME    = 2'd1;
    localparam logic [1:0] FIELD_STATUS  = 2'd2;
    localparam logic [1:0] FIELD_SAT     = 2'd3;

    localparam logic [6:0] MAX_HOUR   = 7'd23;
    localparam logic [6:0] MAX_MINSEC = 7'd59;
    localparam logic [7:0] HOURS_DAY  = 8'd24;

    localparam int TDATA_OUT_W = 48;

    typedef struct packed {
        logic       after_dollar;
        logic       after_star;
        logic [7:0] xor_accumulator;
        logic [15:0] hex_accumulator;
        logic [2:0] hex_digit_count;
        logic       hex_bad;
        logic [1:0] field_count;
        logic       status_seen;
        logic [6:0] hour_digits;
        logic [6:0] minute_digits;
        logic [6:0] second_digits;
        logic [2:0] time_digit_count;
        logic       time_stopped;
    } nsv_state_t;

    typedef struct packed {
        logic        checksum_ok;
        logic [7:0]  computed_checksum;
        logic [15:0] received_checksum;
        logic        checksum_format_error;
        logic        fix_valid;
        logic        time_valid;
        logic [4:0]  local_hour;
        logic [5:0]  time_minute;
        logic [5:0]  time_second;
    } nsv_result_t;

    // {valid, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - CHAR_ZERO;
            return {1'b1, d[3:0]};
        end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
            d = c - CHAR_UP_A + 8'd10;
            return {1'b1, d[3:0]};
        end else if (c >= CHAR_LO_A && c <= CHAR_LO_F) begin
            d = c - CHAR_LO_A + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    // acc * 10 + digit, kept to 7 bits
    function automatic logic [6:0] mul10_add(input logic [6:0] acc, input logic [3:0] dig);
        logic [6:0] t;
        t = {acc[3:0], 3'b000} + {acc[5:0], 1'b0} + {3'b000, dig};
        return t;
    endfunction

endpackage

`default_nettype wire

@@ rtl/nsv_in_stage.sv @@
// input register stage for sentence bytes
`default_nettype none

module nsv_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_char,
    input  wire logic       in_last,
    input  wire logic       out_free,
    output logic            consume,
    output logic [7:0]      char_byte,
    output logic            end_of_sentence
);

    logic       valid_reg;
    logic [7:0] char_reg;
    logic       last_reg;

    // a final byte waits until the result slot is free
    assign consume         = valid_reg && (!last_reg || out_free);
    assign in_ready        = !valid_reg || consume;
    assign char_byte       = char_reg;
    assign end_of_sentence = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            char_reg <= in_char;
            last_reg <= in_last;
        end
    end

endmodule

`default_nettype wire

@@ rtl/nsv_parser.sv @@
// per-byte parse state and result computation
`default_nettype none

module nsv_parser #(
    parameter int CHECKSUM_DIGITS = 4
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         consume,
    input  wire logic [7:0]   char_byte,
    input  wire logic         end_of_sentence,
    input  wire logic [4:0]   zone_offset_hours,
    output nsv_pkg::nsv_result_t result
);

    import nsv_pkg::*;

    localparam logic [2:0] DIGIT_LIMIT = 3'(CHECKSUM_DIGITS);

    nsv_state_t state_reg;
    nsv_state_t state_next;
    logic [4:0] hex_dec;
    logic       is_digit;
    logic [7:0] digit_full;
    logic [3:0] digit;
    logic       time_ok;
    logic [7:0] hour_sum;
    logic [7:0] hour_wrap1;
    logic [7:0] hour_wrap2;

    assign hex_dec    = hex_decode(char_byte);
    assign is_digit   = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);
    assign digit_full = char_byte - CHAR_ZERO;
    assign digit      = digit_full[3:0];

    always_comb
    begin
        state_next = state_reg;

        // field tracking and time/status capture
        if (char_byte == CHAR_COMMA)
        begin
            if (state_reg.field_count != FIELD_SAT)
                state_next.field_count = state_reg.field_count + 2'd1;
        end
        else if (state_reg.field_count == FIELD_TIME)
        begin
            if (!state_reg.time_stopped)
            begin
                if (!is_digit)
                begin
                    state_next.time_stopped = 1'b1;
                end
                else
                begin
                    case (state_reg.time_digit_count) inside
                        3'd0, 3'd1:
                        begin
                            state_next.hour_digits = mul10_add(state_reg.hour_digits, digit);
                            state_next.time_digit_count = state_reg.time_digit_count + 3'd1;
                        end
                        3'd2, 3'd3:
                        begin
                            state_next.minute_digits =
                                mul10_add(state_reg.minute_digits, digit);
                            state_next.time_digit_count = state_reg.time_digit_count + 3'd1;
                        end
                        3'd4, 3'd5:
                        begin
                            state_next.second_digits =
                                mul10_add(state_reg.second_digits, digit);
                            state_next.time_digit_count = state_reg.time_digit_count + 3'd1;
                        end
                        default:
                        begin
                            state_next.time_digit_count = TIME_TOO_LONG;
                            state_next.time_stopped     = 1'b1;
                        end
                    endcase
                end
            end
        end
        else if (state_reg.field_count == FIELD_STATUS && char_byte == CHAR_A)
        begin
            state_next.status_seen = 1'b1;
        end

        // checksum framing
        if (state_reg.after_star)
        begin
            if (!hex_dec[4])
            begin
                state_next.hex_bad = 1'b1;
            end
            else if (state_reg.hex_digit_count < DIGIT_LIMIT)
            begin
                state_next.hex_accumulator = {state_reg.hex_accumulator[11:0], hex_dec[3:0]};
                state_next.hex_digit_count = state_reg.hex_digit_count + 3'd1;
            end
            else
            begin
                state_next.hex_bad = 1'b1;
            end
        end
        else if (char_byte == CHAR_STAR)
        begin
            state_next.after_star = 1'b1;
        end
        else if (char_byte == CHAR_DOLLAR)
        begin
            state_next.after_dollar = 1'b1;
        end
        else if (state_reg.after_dollar)
        begin
            state_next.xor_accumulator = state_reg.xor_accumulator ^ char_byte;
        end
    end

    // result from the state after the final byte
    assign time_ok = (state_next.time_digit_count == TIME_DIGITS)
                  && (state_next.hour_digits <= MAX_HOUR)
                  && (state_next.minute_digits <= MAX_MINSEC)
                  && (state_next.second_digits <= MAX_MINSEC);

    assign hour_sum   = {1'b0, state_next.hour_digits} + {3'b000, zone_offset_hours};
    assign hour_wrap1 = (hour_sum >= HOURS_DAY) ? hour_sum - HOURS_DAY : hour_sum;
    assign hour_wrap2 = (hour_wrap1 >= HOURS_DAY) ? hour_wrap1 - HOURS_DAY : hour_wrap1;

    always_comb
    begin
        result.checksum_ok = state_next.after_star
                          && (state_next.hex_digit_count != 3'd0)
                          && !state_next.hex_bad
                          && (state_next.hex_accumulator == {8'd0, state_next.xor_accumulator});
        result.computed_checksum     = state_next.xor_accumulator;
        result.received_checksum     = state_next.hex_accumulator;
        result.checksum_format_error = state_next.hex_bad;
        result.fix_valid             = state_next.status_seen;
        result.time_valid            = time_ok;
        result.local_hour  = time_ok ? hour_wrap2[4:0] : 5'd0;
        result.time_minute = time_ok ? state_next.minute_digits[5:0] : 6'd0;
        result.time_second = time_ok ? state_next.second_digits[5:0] : 6'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (consume)
        begin
            state_reg <= end_of_sentence ? '0 : state_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/nsv_out_stage.sv @@
// result register driving the output stream
`default_nettype none

module nsv_out_stage (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load,
    input  wire nsv_pkg::nsv_result_t          result,
    output logic                               out_free,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [nsv_pkg::TDATA_OUT_W-1:0]    out_data
);

    import nsv_pkg::*;

    logic        valid_reg;
    nsv_result_t result_reg;

    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;

    // low bit first: ok, computed, received, format error, fix, time valid, hour, min, sec
    assign out_data = {3'b000,
                       result_reg.time_second,
                       result_reg.time_minute,
                       result_reg.local_hour,
                       result_reg.time_valid,
                       result_reg.fix_valid,
                       result_reg.checksum_format_error,
                       result_reg.received_checksum,
                       result_reg.computed_checksum,
                       result_reg.checksum_ok};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire

@@ rtl/nmea_sentence_validator_top.sv @@
// top level of the nmea sentence checker
//
// nmea sentence checker. bytes of one sentence enter on the slave stream, one
// request per byte, with tlast on the final byte. bytes other than '$' strictly
// between the first '$' and the first '*' are xored into the computed checksum;
// every byte after '*' must be a hex digit and up to CHECKSUM_DIGITS of them
// form the received checksum (anything else, or too many digits, raises the
// format error). commas split fields: field one gives hhmmss, field two gives
// the fix status 'A'. for each sentence exactly one result request leaves on
// the master stream after the final byte, and all parse state then clears.
// local_hour is the utc hour plus zone_offset_hours, modulo 24; the offset
// register resets to 8 and is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while the block is idle, the block does not enforce it.
// throughput: one byte per clock unless a final byte is waiting. the final
// byte is taken into the input register, and the parse logic then loads its
// result into the result register. a final byte waits in the input register
// only while an earlier result is still held by the downstream side; other
// bytes never wait.
`default_nettype none

module nmea_sentence_validator_top #(
    parameter int CHECKSUM_DIGITS = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // sentence byte stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  wire logic        s_axis_tlast,   // end_of_sentence
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] checksum_ok, [8:1] computed_checksum, [24:9] received_checksum,
    // [25] checksum_format_error, [26] fix_valid, [27] time_valid,
    // [32:28] local_hour, [38:33] time_minute, [44:39] time_second, [47:45] zero
    output logic [47:0]      m_axis_tdata,
    // zone offset register
    input  wire logic        cfg_wr_en,
    input  wire logic [4:0]  cfg_wr_data
);

    import nsv_pkg::*;

    localparam logic [4:0] ZONE_RESET = 5'd8;

    logic        consume;
    logic        out_free;
    logic [7:0]  char_byte;
    logic        end_of_sentence;
    logic [4:0]  zone_reg;
    nsv_result_t result;

    // zone offset, added as given and wrapped in the parser
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg <= ZONE_RESET;
        end
        else if (cfg_wr_en)
        begin
            zone_reg <= cfg_wr_data;
        end
    end

    // input register holds one byte request
    nsv_in_stage u_in (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .in_char         (s_axis_tdata),
        .in_last         (s_axis_tlast),
        .out_free        (out_free),
        .consume         (consume),
        .char_byte       (char_byte),
        .end_of_sentence (end_of_sentence)
    );

    // parse state updates once per consumed byte
    nsv_parser #(
        .CHECKSUM_DIGITS (CHECKSUM_DIGITS)
    ) u_parse (
        .clk               (clk),
        .rst_n             (rst_n),
        .consume           (consume),
        .char_byte         (char_byte),
        .end_of_sentence   (end_of_sentence),
        .zone_offset_hours (zone_reg),
        .result            (result)
    );

    // result register, loaded on the final byte of a sentence
    nsv_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (consume && end_of_sentence),
        .result    (result),
        .out_free  (out_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

@@ tb/nsv_tb_pkg.sv @@
// sentence tracker that predicts the nmea checker's per-sentence results
package nsv_tb_pkg;

    import nsv_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    class sentence_tracker;
        int unsigned digit_limit;
        logic [4:0]  zone_offset;

        logic        in_body;
        logic        in_tail;
        logic [7:0]  running_xor;
        logic [15:0] tail_value;
        logic [2:0]  tail_digits;
        logic        tail_bad;
        logic [1:0]  commas;
        logic        fix_seen;
        logic [6:0]  hh;
        logic [6:0]  mm;
        logic [6:0]  ss;
        logic [2:0]  clock_digits;
        logic        clock_done;

        nsv_result_t due_verdicts[$];
        int unsigned verdicts_noted;
        int unsigned verdicts_matched;
        int unsigned mismatches;

        function new(int unsigned max_digits);
            digit_limit = max_digits;
            zone_offset = 5'd8;
            verdicts_noted = 0;
            verdicts_matched = 0;
            mismatches = 0;
            clear_sentence();
        endfunction

        function void clear_sentence();
            in_body = 1'b0;
            in_tail = 1'b0;
            running_xor = 8'd0;
            tail_value = 16'd0;
            tail_digits = 3'd0;
            tail_bad = 1'b0;
            commas = 2'd0;
            fix_seen = 1'b0;
            hh = 7'd0;
            mm = 7'd0;
            ss = 7'd0;
            clock_digits = 3'd0;
            clock_done = 1'b0;
        endfunction

        function int pending();
            return due_verdicts.size();
        endfunction

        // one accepted sentence byte; the final byte queues the sentence verdict
        function void take_byte(logic [7:0] c, logic eos);
            logic [3:0]  d;
            logic [3:0]  nib;
            logic        is_hex;
            logic        tv;
            nsv_result_t r;

            // field tracking runs on every byte, also after the star
            if (c == CHAR_COMMA) begin
                if (commas != FIELD_SAT)
                    commas++;
            end else if (commas == FIELD_TIME) begin
                if (!clock_done) begin
                    if (c < CHAR_ZERO || c > CHAR_NINE) begin
                        clock_done = 1'b1;
                    end else begin
                        d = 4'(c - CHAR_ZERO);
                        case (clock_digits)
                            3'd0, 3'd1: hh = 7'(hh * 10 + d);
                            3'd2, 3'd3: mm = 7'(mm * 10 + d);
                            3'd4, 3'd5: ss = 7'(ss * 10 + d);
                            default:
                            begin
                                clock_digits = TIME_TOO_LONG;
                                clock_done = 1'b1;
                            end
                        endcase
                        if (!clock_done)
                            clock_digits++;
                    end
                end
            end else if (commas == FIELD_STATUS && c == CHAR_A) begin
                fix_seen = 1'b1;
            end

            if (in_tail) begin
                is_hex = 1'b1;
                nib = 4'd0;
                if (c >= CHAR_ZERO && c <= CHAR_NINE)
                    nib = 4'(c - CHAR_ZERO);
                else if (c >= CHAR_UP_A && c <= CHAR_UP_F)
                    nib = 4'(c - CHAR_UP_A + 8'd10);
                else if (c >= CHAR_LO_A && c <= CHAR_LO_F)
                    nib = 4'(c - CHAR_LO_A + 8'd10);
                else
                    is_hex = 1'b0;
                if (!is_hex || tail_digits >= digit_limit) begin
                    tail_bad = 1'b1;
                end else begin
                    tail_value = {tail_value[11:0], nib};
                    tail_digits++;
                end
            end else if (c == CHAR_STAR) begin
                in_tail = 1'b1;
            end else if (c == CHAR_DOLLAR) begin
                in_body = 1'b1;
            end else if (in_body) begin
                running_xor ^= c;
            end

            if (!eos)
                return;

            tv = clock_digits == TIME_DIGITS && hh <= MAX_HOUR &&
                 mm <= MAX_MINSEC && ss <= MAX_MINSEC;
            r.checksum_ok = in_tail && tail_digits != 3'd0 && !tail_bad &&
                            tail_value == {8'd0, running_xor};
            r.computed_checksum = running_xor;
            r.received_checksum = tail_value;
            r.checksum_format_error = tail_bad;
            r.fix_valid = fix_seen;
            r.time_valid = tv;
            r.local_hour = tv ? 5'((int'(hh) + int'(zone_offset)) % 24) : 5'd0;
            r.time_minute = tv ? mm[5:0] : 6'd0;
            r.time_second = tv ? ss[5:0] : 6'd0;
            due_verdicts.push_back(r);
            verdicts_noted++;
            clear_sentence();
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                mismatches++;
                $display("%0t: %s expected %0h got %0h", $time, field, want, got);
            end
        endfunction

        // one result taken off the master stream
        function void match_verdict(logic [47:0] word);
            nsv_result_t want;
            if (due_verdicts.size() == 0) begin
                mismatches++;
                $display("%0t: result %h arrived with none expected", $time, word);
                return;
            end
            want = due_verdicts.pop_front();
            verdicts_matched++;
            compare_field("checksum_ok", want.checksum_ok, word[0]);
            compare_field("computed_checksum", want.computed_checksum, word[8:1]);
            compare_field("received_checksum", want.received_checksum, word[24:9]);
            compare_field("checksum_format_error", want.checksum_format_error, word[25]);
            compare_field("fix_valid", want.fix_valid, word[26]);
            compare_field("time_valid", want.time_valid, word[27]);
            compare_field("local_hour", want.local_hour, word[32:28]);
            compare_field("time_minute", want.time_minute, word[38:33]);
            compare_field("time_second", want.time_second, word[44:39]);
            compare_field("pad bits", 0, word[47:45]);
        endfunction
    endclass

endpackage

@@ tb/tb_top.sv @@
// stream-level testbench for the nmea sentence checker
module tb_top;

    import nsv_pkg::*;
    import nsv_tb_pkg::*;

    localparam int HEX_DIGITS      = 4;
    // a result is registered after the final byte is taken; a little margin on top
    localparam int SETTLE_CYCLES   = 4;
    // random traffic per flow-control phase
    localparam int PHASE_BYTES     = 200;
    localparam int PHASE_SENTENCES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;      // [7:0] char_byte
    logic        s_axis_tlast = 1'b0;      // end_of_sentence
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [0] checksum_ok, [8:1] computed_checksum, [24:9] received_checksum,
    // [25] checksum_format_error, [26] fix_valid, [27] time_valid,
    // [32:28] local_hour, [38:33] time_minute, [44:39] time_second
    logic [47:0] m_axis_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [4:0]  cfg_wr_data = 5'd0;

    // chance in percent of a sender gap / a receiver stall on a given cycle
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned bytes_sent = 0;

    sentence_tracker tracker = new(HEX_DIGITS);

    nmea_sentence_validator_top #(
        .CHECKSUM_DIGITS(HEX_DIGITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // result side: sample at the edge (pre-edge values), then pick next tready
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                tracker.match_verdict(m_axis_tdata);
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // one byte request; returns in the time step of the edge that took it.
    // tvalid stays high on return, so the caller must drive the next byte or
    // drop tvalid in that same step
    task automatic send_byte(input logic [7:0] c, input logic eos);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eos;
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.take_byte(c, eos);
        bytes_sent++;
    endtask

    // whole sentence, tlast on its final byte
    task automatic send_line(input byte_q_t line);
        foreach (line[i])
            send_byte(line[i], i == line.size() - 1);
    endtask

    task automatic send_text(input string s);
        byte_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        send_line(q);
    endtask

    // offset write only once every sentence has reported and the pipe is empty
    task automatic write_offset(input logic [4:0] v);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.zone_offset = v;
    endtask

    // mostly well-formed sentences with random content, some cut short or
    // missing the dollar, and some plain byte noise
    function automatic void build_sentence(output byte_q_t line);
        int unsigned kind;
        int unsigned ndig;
        int unsigned want;
        int unsigned cut;
        int unsigned v;
        logic [7:0]  sum;
        logic [7:0]  ch;
        logic        lower;
        byte_q_t     q;
        string       hexu;

        hexu = "0123456789ABCDEF";
        kind = $urandom_range(99);
        if (kind >= 90) begin
            repeat ($urandom_range(1, 10)) q.push_back(8'($urandom_range(255)));
            line = q;
            return;
        end

        q.push_back(CHAR_DOLLAR);
        repeat (5) q.push_back(8'($urandom_range(CHAR_UP_A, 8'h5A)));
        q.push_back(CHAR_COMMA);

        // time field: usually a legal hhmmss, else a random run of digits
        if ($urandom_range(99) < 70) begin
            v = $urandom_range(23);
            q.push_back(8'(CHAR_ZERO + v / 10));
            q.push_back(8'(CHAR_ZERO + v % 10));
            v = $urandom_range(59);
            q.push_back(8'(CHAR_ZERO + v / 10));
            q.push_back(8'(CHAR_ZERO + v % 10));
            v = $urandom_range(59);
            q.push_back(8'(CHAR_ZERO + v / 10));
            q.push_back(8'(CHAR_ZERO + v % 10));
        end else begin
            repeat ($urandom_range(0, 8)) q.push_back(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
        end
        if ($urandom_range(1)) begin
            q.push_back(".");
            q.push_back(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
            q.push_back(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
        end
        q.push_back(CHAR_COMMA);

        if ($urandom_range(1))
            q.push_back(CHAR_A);
        else
            q.push_back("V");
        q.push_back(CHAR_COMMA);

        repeat ($urandom_range(0, 4))
        begin
            do
                ch = 8'($urandom_range(32, 126));
            while (ch == CHAR_STAR || ch == CHAR_DOLLAR);
            q.push_back(ch);
        end

        // only the leading dollar is excluded from the xor
        sum = 8'd0;
        foreach (q[i])
            if (i > 0)
                sum ^= q[i];
        q.push_back(CHAR_STAR);

        // two digits usual; short, padded and over-long forms too
        case ($urandom_range(9))
            0:       ndig = 1;
            1:       ndig = 3;
            2:       ndig = 4;
            3:       ndig = 5;
            default: ndig = 2;
        endcase
        want = ($urandom_range(9) == 0) ? $urandom_range(65535) : sum;
        lower = 1'($urandom_range(1));
        for (int i = int'(ndig) - 1; i >= 0; i--)
        begin
            ch = hexu[(want >> (4 * i)) & 15];
            if (lower && ch >= CHAR_UP_A)
                ch = ch | 8'h20;    // to lower case
            q.push_back(ch);
        end
        if ($urandom_range(9) == 0) begin
            q.push_back(8'h0D);
            q.push_back(8'h0A);
        end

        // broken sentences: maybe no dollar, then truncated anywhere
        if (kind >= 75) begin
            if ($urandom_range(3) == 0)
                void'(q.pop_front());
            cut = $urandom_range(1, q.size());
            while (q.size() > cut)
                void'(q.pop_back());
        end
        line = q;
    endfunction

    task automatic run_phase(input int unsigned idle, input int unsigned stall,
                             input logic [4:0] offset);
        int unsigned first_byte;
        int unsigned first_verdict;
        byte_q_t     line;
        write_offset(offset);
        idle_pct = idle;
        stall_pct = stall;
        first_byte = bytes_sent;
        first_verdict = tracker.verdicts_noted;
        while (bytes_sent - first_byte < PHASE_BYTES ||
               tracker.verdicts_noted - first_verdict < PHASE_SENTENCES)
        begin
            build_sentence(line);
            send_line(line);
        end
    endtask

    initial
    begin
        int unsigned guard;
        int unsigned leftover;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed sentences, offset still at its reset value
        send_text("$a$*61");        // second dollar skipped, checksum matches
        send_text(",235959,A*G");   // no dollar, max time, fix, non-hex after star
        send_text("*12345");        // one digit too many
        send_text("*");             // star with no digits
        send_byte(8'hFF, 1'b1);     // top byte value alone
        send_byte(8'h00, 1'b1);     // nul alone

        // random traffic under each flow-control mix and offset
        run_phase(0, 0, 5'd23);
        run_phase(85, 0, 5'd0);
        run_phase(0, 85, 5'd31);
        run_phase(15, 15, 5'($urandom_range(1, 22)));
        s_axis_tvalid <= 1'b0;

        // drain what is still in flight
        guard = 0;
        while (tracker.pending() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        leftover = tracker.pending();
        if (leftover != 0)
            $display("%0t: %0d results never arrived", $time, leftover);

        $display("sent %0d sentence bytes, checked %0d results, %0d field mismatches",
                 bytes_sent, tracker.verdicts_matched, tracker.mismatches);
        $display("flow phases: free, sender gaps, result stalls, mixed; offsets 8, 23, 0, 31, random");
        if (tracker.mismatches == 0 && leftover == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // hard stop in case the handshakes hang
    initial
    begin
        #3000000;
        $display("%0t: run did not finish in time", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/nsv_pkg.sv
rtl/nsv_in_stage.sv
rtl/nsv_parser.sv
rtl/nsv_out_stage.sv
rtl/nmea_sentence_validator_top.sv
tb/nsv_tb_pkg.sv
tb/tb_top.sv
